// ===== sv/sitrt_pkg.sv =====
// Shared types, constants and reciprocal table for the signed radix text converter.
`timescale 1ns / 1ps

package sitrt_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_BITS  = 4;
    localparam int CHAR_BITS   = 8;
    localparam int RADIX_BITS  = 5;
    localparam int COUNT_BITS  = 6;
    localparam int ADDR_BITS   = 5;
    localparam int DEPTH       = 32;
    localparam int RECIP_BITS  = 32;
    localparam int PROD_BITS   = VALUE_BITS + RECIP_BITS;
    localparam int REM_BITS    = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CHAR_BITS-1:0]     MINUS_CODE = 8'h2D;
    localparam logic [RADIX_BITS-1:0]    RADIX_MIN  = 5'd2;
    localparam logic [RADIX_BITS-1:0]    RADIX_MAX  = 5'd16;
    localparam logic [RADIX_BITS-1:0]    RADIX_RST  = 5'd10;
    localparam logic [CFG_DATA_BITS-1:0] SYM_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_DATA_BITS-1:0] SYM_HIGH_RST = 64'h6665646362613938;

    localparam logic [CFG_IDX_BITS-1:0] REG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYM_HIGH = 2'd2;

    // One division step result: quotient and digit.
    typedef struct packed {
        logic [VALUE_BITS-1:0] quot;
        logic [DIGIT_BITS-1:0] rem;
    } div_res_t;

    // floor(2^32 / radix); the estimate it gives is the quotient or one short.
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [RADIX_BITS-1:0] r);
        logic [RECIP_BITS-1:0] v;
        unique case (r)
            5'd2:    v = 32'd2147483648;
            5'd3:    v = 32'd1431655765;
            5'd4:    v = 32'd1073741824;
            5'd5:    v = 32'd858993459;
            5'd6:    v = 32'd715827882;
            5'd7:    v = 32'd613566756;
            5'd8:    v = 32'd536870912;
            5'd9:    v = 32'd477218588;
            5'd10:   v = 32'd429496729;
            5'd11:   v = 32'd390451572;
            5'd12:   v = 32'd357913941;
            5'd13:   v = 32'd330382099;
            5'd14:   v = 32'd306783378;
            5'd15:   v = 32'd286331153;
            5'd16:   v = 32'd268435456;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/sitrt_divider.sv =====
// Shared divide-by-radix unit: reciprocal multiply, then one correction step.
`timescale 1ns / 1ps

module sitrt_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sitrt_pkg::VALUE_BITS-1:0]    dividend,
    input  logic [sitrt_pkg::RADIX_BITS-1:0]    radix,
    output logic                                done,
    output sitrt_pkg::div_res_t                 res
);

    logic [sitrt_pkg::PROD_BITS-1:0]  prod_reg;
    logic [sitrt_pkg::REM_BITS-1:0]   lowm_reg;
    logic                             pend_reg;

    logic [sitrt_pkg::VALUE_BITS-1:0] q0;
    logic [sitrt_pkg::REM_BITS-1:0]   qr_low;
    logic [sitrt_pkg::REM_BITS-1:0]   rem6;
    logic [sitrt_pkg::REM_BITS-1:0]   radix6;
    logic [2*sitrt_pkg::REM_BITS-1:0] qr_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= sitrt_pkg::PROD_BITS'(dividend) *
                        sitrt_pkg::PROD_BITS'(sitrt_pkg::recip_of(radix));
            lowm_reg <= dividend[sitrt_pkg::REM_BITS-1:0];
        end
    end

    // True remainder of the estimate lies below twice the radix, so six bits carry it.
    always_comb
    begin
        radix6  = sitrt_pkg::REM_BITS'(radix);
        q0      = prod_reg[sitrt_pkg::PROD_BITS-1:sitrt_pkg::RECIP_BITS];
        qr_full = (2*sitrt_pkg::REM_BITS)'(q0[sitrt_pkg::REM_BITS-1:0]) *
                  (2*sitrt_pkg::REM_BITS)'(radix6);
        qr_low  = qr_full[sitrt_pkg::REM_BITS-1:0];
        rem6    = lowm_reg - qr_low;
        if (rem6 >= radix6)
        begin
            res.quot = q0 + sitrt_pkg::VALUE_BITS'(1);
            res.rem  = sitrt_pkg::DIGIT_BITS'(rem6 - radix6);
        end
        else
        begin
            res.quot = q0;
            res.rem  = sitrt_pkg::DIGIT_BITS'(rem6);
        end
    end

    assign done = pend_reg;

endmodule

// ===== sv/sitrt_digit_buf.sv =====
// Digit buffer: one write port, one read port, least significant digit at address zero.
`timescale 1ns / 1ps

module sitrt_digit_buf (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [sitrt_pkg::ADDR_BITS-1:0]    wr_addr,
    input  logic [sitrt_pkg::DIGIT_BITS-1:0]   wr_data,
    input  logic [sitrt_pkg::ADDR_BITS-1:0]    rd_addr,
    output logic [sitrt_pkg::DIGIT_BITS-1:0]   rd_data
);

    logic [sitrt_pkg::DIGIT_BITS-1:0] digit_reg [sitrt_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = digit_reg[rd_addr];

endmodule

// ===== sv/signed_integer_to_radix_text.sv =====
// Top level: signed 32-bit integer to radix text, one character per output request.
`timescale 1ns / 1ps

// Takes one signed 32-bit value per input request and sends its text in the
// configured radix (2 to 16), most significant digit first, a leading '-' for
// negative values, tlast on the final character. Digits come from a shared
// divide-by-radix unit (reciprocal multiply plus one correction), one digit per
// pass through ST_START and ST_WAIT, least significant first, into a 32-entry
// digit buffer; the characters then leave at one per cycle through an output
// register while m_tready does not stall them. An item sends one character per
// digit, plus the '-' when negative, and holds s_tready low until its final
// character is loaded into the output register. Registers: index 0
// radix (clamped to 2..16), 1 symbols 0..7, 2 symbols 8..15; write them only
// while idle. cfg_ready is always high; writes to index 3 are dropped.

module signed_integer_to_radix_text (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // value
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [sitrt_pkg::VALUE_BITS-1:0]      s_tdata,
    // char_code
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sitrt_pkg::CHAR_BITS-1:0]       m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sitrt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sitrt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                                state_reg, state_next;
    logic [sitrt_pkg::RADIX_BITS-1:0]      radix_reg, radix_next;
    logic [sitrt_pkg::CFG_DATA_BITS-1:0]   sym_low_reg, sym_low_next;
    logic [sitrt_pkg::CFG_DATA_BITS-1:0]   sym_high_reg, sym_high_next;
    logic [sitrt_pkg::VALUE_BITS-1:0]      mag_reg, mag_next;
    logic [sitrt_pkg::COUNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [sitrt_pkg::COUNT_BITS-1:0]      idx_reg, idx_next;
    logic                                  neg_reg, neg_next;
    logic                                  mvalid_reg, mvalid_next;
    logic [sitrt_pkg::CHAR_BITS-1:0]       mdata_reg, mdata_next;
    logic                                  mlast_reg, mlast_next;

    logic                                  div_start, div_done;
    sitrt_pkg::div_res_t                   div_res;
    logic                                  wr_en;
    logic [sitrt_pkg::ADDR_BITS-1:0]       rd_addr;
    logic [sitrt_pkg::DIGIT_BITS-1:0]      rd_digit;
    logic [sitrt_pkg::COUNT_BITS-1:0]      idx_m1;
    logic [2*sitrt_pkg::CFG_DATA_BITS-1:0] sym_tbl;
    logic [sitrt_pkg::CHAR_BITS-1:0]       sym;
    logic [sitrt_pkg::RADIX_BITS-1:0]      cfg_radix;
    logic                                  load;

    sitrt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .radix    (radix_reg),
        .done     (div_done),
        .res      (div_res)
    );

    sitrt_digit_buf u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[sitrt_pkg::ADDR_BITS-1:0]),
        .wr_data (div_res.rem),
        .rd_addr (rd_addr),
        .rd_data (rd_digit)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tlast   = mlast_reg;
    assign div_start = (state_reg == ST_START);
    assign wr_en     = (state_reg == ST_WAIT) && div_done;
    assign idx_m1    = idx_reg - sitrt_pkg::COUNT_BITS'(1);
    assign rd_addr   = idx_m1[sitrt_pkg::ADDR_BITS-1:0];
    assign sym_tbl   = {sym_high_reg, sym_low_reg};
    assign sym       = sym_tbl[{rd_digit, 3'b000} +: sitrt_pkg::CHAR_BITS];
    assign load      = !mvalid_reg || m_tready;

    always_comb
    begin
        cfg_radix = cfg_data[sitrt_pkg::RADIX_BITS-1:0];
        if (cfg_radix < sitrt_pkg::RADIX_MIN)
        begin
            cfg_radix = sitrt_pkg::RADIX_MIN;
        end
        else if (cfg_radix > sitrt_pkg::RADIX_MAX)
        begin
            cfg_radix = sitrt_pkg::RADIX_MAX;
        end
    end

    always_comb
    begin
        radix_next    = radix_reg;
        sym_low_next  = sym_low_reg;
        sym_high_next = sym_high_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sitrt_pkg::REG_RADIX:    radix_next    = cfg_radix;
                sitrt_pkg::REG_SYM_LOW:  sym_low_next  = cfg_data;
                sitrt_pkg::REG_SYM_HIGH: sym_high_next = cfg_data;
                default:                 radix_next    = radix_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next   = s_tdata[sitrt_pkg::VALUE_BITS-1];
                    mag_next   = s_tdata[sitrt_pkg::VALUE_BITS-1] ?
                                 (sitrt_pkg::VALUE_BITS'(0) - s_tdata) : s_tdata;
                    cnt_next   = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    mag_next = div_res.quot;
                    cnt_next = cnt_reg + sitrt_pkg::COUNT_BITS'(1);
                    if ((div_res.quot == '0) ||
                        (cnt_reg == sitrt_pkg::COUNT_BITS'(sitrt_pkg::DEPTH - 1)))
                    begin
                        idx_next   = cnt_reg + sitrt_pkg::COUNT_BITS'(1);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    mvalid_next = 1'b1;
                    if (neg_reg)
                    begin
                        mdata_next = sitrt_pkg::MINUS_CODE;
                        mlast_next = 1'b0;
                        neg_next   = 1'b0;
                    end
                    else
                    begin
                        mdata_next = sym;
                        mlast_next = (idx_reg == sitrt_pkg::COUNT_BITS'(1));
                        idx_next   = idx_m1;
                        if (idx_reg == sitrt_pkg::COUNT_BITS'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            radix_reg    <= sitrt_pkg::RADIX_RST;
            sym_low_reg  <= sitrt_pkg::SYM_LOW_RST;
            sym_high_reg <= sitrt_pkg::SYM_HIGH_RST;
            mag_reg      <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            neg_reg      <= 1'b0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            radix_reg    <= radix_next;
            sym_low_reg  <= sym_low_next;
            sym_high_reg <= sym_high_next;
            mag_reg      <= mag_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            neg_reg      <= neg_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

endmodule
